[rtl/ldoc_pkg.sv]
// Shared types and constants for the list duplicate and order checker.
package ldoc_pkg;

  localparam int VALUE_W            = 32;
  localparam int COUNT_W            = 10;
  localparam int LIST_DEPTH_DEFAULT = 512;

  // Control part of a token that moves down the cell chain.
  typedef struct packed {
    logic valid;
    logic last;
    logic dup;
  } tok_ctl_t;

endpackage

[rtl/ldoc_in_if.sv]
// Input channel: one list element per request.
interface ldoc_in_if;
  import ldoc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

[rtl/ldoc_out_if.sv]
// Output channel: one summary per list.
interface ldoc_out_if;
  import ldoc_pkg::*;

  logic               valid;
  logic               ready;
  logic               has_duplicate;
  logic               in_order;
  logic [COUNT_W-1:0] element_count;
  logic               overflow;

  modport source (output valid, output has_duplicate, output in_order,
                  output element_count, output overflow, input ready);
  modport sink   (input valid, input has_duplicate, input in_order,
                  input element_count, input overflow, output ready);
endinterface

[rtl/ldoc_cell.sv]
// One chain cell: holds the list element of its position and checks passing tokens.
module ldoc_cell
  import ldoc_pkg::*;
#(
  parameter int CW  = 10,
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  tok_ctl_t                  ctl_in,
  input  logic [CW-1:0]             idx_in,
  input  logic signed [VALUE_W-1:0] value_in,
  output tok_ctl_t                  ctl_out,
  output logic [CW-1:0]             idx_out,
  output logic signed [VALUE_W-1:0] value_out
);

  logic signed [VALUE_W-1:0] stored;
  logic                      hit;
  logic                      take;

  // Compare only against an entry that belongs to an earlier element of the same list.
  assign hit  = ctl_in.valid && (idx_in > CW'(IDX)) && (stored == value_in);
  assign take = ctl_in.valid && (idx_in == CW'(IDX));

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (advance) begin
      ctl_out.valid <= ctl_in.valid;
      ctl_out.last  <= ctl_in.last;
      ctl_out.dup   <= ctl_in.dup | hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      idx_out   <= idx_in;
      value_out <= value_in;
      if (take) begin
        stored <= value_in;
      end
    end
  end

endmodule

[rtl/ldoc_tail.sv]
// Chain tail: folds tokens into per-list flags and holds the result register.
module ldoc_tail
  import ldoc_pkg::*;
#(
  parameter int CW    = 10,
  parameter int DEPTH = 512
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tok_ctl_t                  ctl,
  input  logic [CW-1:0]             idx,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      advance,
  ldoc_out_if.source                results
);

  logic                      dup_acc;
  logic                      desc_acc;
  logic                      ovf_acc;
  logic signed [VALUE_W-1:0] prev;

  logic          dup_all;
  logic          desc_all;
  logic          ovf_all;
  logic [CW-1:0] count;
  logic          fire;

  // Stall the chain only when a finished list meets a full, untaken result.
  assign advance = !(ctl.valid && ctl.last && results.valid && !results.ready);
  assign fire    = ctl.valid && advance;

  assign dup_all  = dup_acc | ctl.dup;
  assign desc_all = desc_acc | ((idx != '0) && (value < prev));
  assign ovf_all  = ovf_acc | (idx == CW'(DEPTH));
  assign count    = (idx == CW'(DEPTH)) ? idx : idx + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dup_acc       <= 1'b0;
      desc_acc      <= 1'b0;
      ovf_acc       <= 1'b0;
      prev          <= '0;
      results.valid <= 1'b0;
    end else begin
      if (fire && ctl.last) begin
        results.valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end
      if (fire) begin
        if (ctl.last) begin
          dup_acc               <= 1'b0;
          desc_acc              <= 1'b0;
          ovf_acc               <= 1'b0;
          prev                  <= '0;
          results.has_duplicate <= dup_all;
          results.in_order      <= !desc_all;
          results.element_count <= COUNT_W'(count);
          results.overflow      <= ovf_all;
        end else begin
          dup_acc  <= dup_all;
          desc_acc <= desc_all;
          ovf_acc  <= ovf_all;
          prev     <= value;
        end
      end
    end
  end

  a_load_from_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && !$past(results.valid) |-> $past(ctl.valid && ctl.last))
    else $error("result appeared without a last token");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !advance |-> results.valid && !results.ready)
    else $error("chain stalled with free result register");

  a_ovf_count: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.overflow |-> results.element_count == COUNT_W'(DEPTH))
    else $error("overflow reported with unsaturated count");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready |=> results.valid && $stable(results.element_count))
    else $error("stalled result changed");

endmodule

[rtl/list_duplicate_and_order_check.sv]
// A list's last element passes every chain cell and then the tail result register.
// Throughput: one element per cycle; each token moves one cell per cycle down the chain.
// The chain stalls only while a finished list waits behind an untaken result.
// Reset (rst, synchronous) clears token control bits, the index counter, the tail flags and result valid.
// Stored element values are not cleared; a cell is read only after this list wrote it.
// The per-element store sits in the cells, so no clearing pass follows reset.
module list_duplicate_and_order_check
  import ldoc_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  ldoc_in_if.sink     items,
  ldoc_out_if.source  results
);

  // Index width holds 0..LIST_DEPTH; LIST_DEPTH itself marks an element past capacity.
  localparam int CW = $clog2(LIST_DEPTH + 1);

  tok_ctl_t                  ctl   [0:LIST_DEPTH];
  logic [CW-1:0]             idx   [0:LIST_DEPTH];
  logic signed [VALUE_W-1:0] value [0:LIST_DEPTH];

  logic          advance;
  logic [CW-1:0] pos;
  logic [CW-1:0] pos_next;

  // Accept whenever the chain moves.
  assign items.ready = advance;

  // Position of the incoming element in its list; saturate at capacity, restart after last.
  always_comb begin
    if (items.last) begin
      pos_next = '0;
    end else if (pos == CW'(LIST_DEPTH)) begin
      pos_next = pos;
    end else begin
      pos_next = pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (items.valid && items.ready) begin
      pos <= pos_next;
    end
  end

  // Head of the chain: the new request becomes a token with a clean duplicate flag.
  assign ctl[0].valid = items.valid;
  assign ctl[0].last  = items.last;
  assign ctl[0].dup   = 1'b0;
  assign idx[0]       = pos;
  assign value[0]     = items.value;

  // Cell k keeps element k of the current list and flags any later element equal to it.
  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    ldoc_cell #(
      .CW  (CW),
      .IDX (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .ctl_in    (ctl[k]),
      .idx_in    (idx[k]),
      .value_in  (value[k]),
      .ctl_out   (ctl[k+1]),
      .idx_out   (idx[k+1]),
      .value_out (value[k+1])
    );
  end

  // Tail: duplicate fold, order check, count, overflow, and the result register.
  ldoc_tail #(
    .CW    (CW),
    .DEPTH (LIST_DEPTH)
  ) u_tail (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl[LIST_DEPTH]),
    .idx     (idx[LIST_DEPTH]),
    .value   (value[LIST_DEPTH]),
    .advance (advance),
    .results (results)
  );

endmodule
